// ===== rtl/fbtc_pkg.sv =====
// fbtc_pkg: word types, register indexes and symbol helper for the five-bit text codec
// no dependencies; imported by five_bit_text_codec and tb
`default_nettype none

package fbtc_pkg;

	typedef struct packed {
		logic       operation;
		logic [7:0] data;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last;
	} out_item_t;

	localparam logic [1:0] CFG_DECODE_MODE = 2'd0;
	localparam logic [1:0] CFG_LINE_LIMIT  = 2'd1;

	localparam logic OP_DATA  = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam logic [7:0] LINE_LIMIT_RESET = 8'd71;
	localparam logic [7:0] FLUSH_EXTRA_MAX  = 8'd60;
	localparam logic [7:0] NEWLINE          = 8'h0A;
	localparam logic [7:0] SYM_ALPHA_BASE   = 8'h41;
	localparam logic [7:0] SYM_ALPHA_END    = 8'h5A;
	localparam logic [7:0] SYM_DIGIT_BASE   = 8'h30;
	localparam logic [7:0] SYM_DIGIT_END    = 8'h35;
	localparam logic [4:0] SYM_ALPHA_CNT    = 5'd26;

	// 5-bit value to alphabet symbol: A-Z then 0-5
	function automatic logic [7:0] sym_of(input logic [4:0] v);
		logic [7:0] w;
		w = {3'b000, v};
		if (v < SYM_ALPHA_CNT) begin
			sym_of = SYM_ALPHA_BASE + w;
		end else begin
			sym_of = SYM_DIGIT_BASE + w - {3'b000, SYM_ALPHA_CNT};
		end
	endfunction

endpackage

`default_nettype wire

// ===== rtl/five_bit_text_codec.sv =====
// five_bit_text_codec: base32-style encoder/decoder, alphabet A-Z then 0-5, msb first
// depends on fbtc_pkg (word types, register indexes, sym_of)
//
//  channel  | signals                                | direction
//  ---------+----------------------------------------+----------
//  item     | item_valid, item_ready, item           | in
//  result   | result_valid, result_ready, result     | out
//  config   | cfg_we, cfg_index, cfg_wdata           | in
//
// an item is registered in the stage register on acceptance and, once the result
// register can take it, processed into a three-entry result register, whose
// first word is then valid and can be taken while result_ready is high
// an item with k results (k = 0..3) keeps the result register until all are taken,
// so items with at most one result flow at one per cycle while results are taken
// a stalled result side stops the stage register, which then holds the next item
// arst_n clears the stream state, the stage and the result register; line_limit
// resets to 71, decode_mode to encode
`default_nettype none

module five_bit_text_codec (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire fbtc_pkg::in_item_t  item,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output fbtc_pkg::out_item_t      result,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [7:0]          cfg_wdata
);
	import fbtc_pkg::*;

	logic        decode_mode_q;
	logic [7:0]  line_limit_q;
	logic [11:0] bit_buffer_q;
	logic [3:0]  bit_count_q;
	logic [7:0]  byte_count_q;

	logic        valid_s1;
	in_item_t    item_s1;

	logic [7:0]  chars_q [3];
	logic [1:0]  res_left_q;

	logic        adv;
	logic [7:0]  nxt_chars [3];
	logic [1:0]  nxt_cnt;
	logic [11:0] nxt_buffer;
	logic [3:0]  nxt_bit_count;
	logic [7:0]  nxt_byte_count;

	// stage advances when the result register is empty or drains its last word now
	assign adv = valid_s1 &&
		((res_left_q == 2'd0) || ((res_left_q == 2'd1) && result_ready));
	assign item_ready = !valid_s1 || adv;

	assign result_valid    = (res_left_q != 2'd0);
	assign result.out_char = chars_q[0];
	assign result.last     = (res_left_q == 2'd1);

	always_comb begin
		logic [4:0]  cnt_e;
		logic [19:0] acc_e;
		logic        two;
		logic [4:0]  rem_e;
		logic [7:0]  s1;
		logic [7:0]  s2;
		logic [7:0]  bcnt_inc;
		logic        nl;
		logic [11:0] pad;
		logic [7:0]  fsym;
		logic        have;
		logic        extra;
		logic        ok;
		logic [4:0]  v;
		logic [16:0] acc_d;
		logic [4:0]  cnt_d;
		logic        ge;
		logic [4:0]  rem_d;

		// encode data word
		cnt_e    = {1'b0, bit_count_q} + 5'd8;
		acc_e    = {bit_buffer_q, item_s1.data};
		two      = (cnt_e >= 5'd10);
		rem_e    = two ? (cnt_e - 5'd10) : (cnt_e - 5'd5);
		s1       = sym_of(5'(acc_e >> (cnt_e - 5'd5)));
		s2       = sym_of(5'(acc_e >> (cnt_e - 5'd10)));
		bcnt_inc = (byte_count_q == 8'hFF) ? 8'hFF : byte_count_q + 8'd1;
		nl       = (bcnt_inc > line_limit_q);

		// encode flush: leftover bits padded on the right
		have  = (bit_count_q != 4'd0);
		extra = (byte_count_q > FLUSH_EXTRA_MAX);
		if (bit_count_q < 4'd5) begin
			pad = bit_buffer_q << (4'd5 - bit_count_q);
		end else begin
			pad = bit_buffer_q >> (bit_count_q - 4'd5);
		end
		fsym = sym_of(pad[4:0]);

		// decode data word
		ok = 1'b1;
		v  = 5'd0;
		if (item_s1.data >= SYM_ALPHA_BASE && item_s1.data <= SYM_ALPHA_END) begin
			v = 5'(item_s1.data - SYM_ALPHA_BASE);
		end else if (item_s1.data >= SYM_DIGIT_BASE && item_s1.data <= SYM_DIGIT_END) begin
			v = 5'(item_s1.data - SYM_DIGIT_BASE) + SYM_ALPHA_CNT;
		end else begin
			ok = 1'b0;
		end
		acc_d = {bit_buffer_q, v};
		cnt_d = {1'b0, bit_count_q} + 5'd5;
		ge    = (cnt_d >= 5'd8);
		rem_d = ge ? (cnt_d - 5'd8) : cnt_d;

		nxt_chars[0]   = s1;
		nxt_chars[1]   = NEWLINE;
		nxt_chars[2]   = NEWLINE;
		nxt_cnt        = 2'd0;
		nxt_buffer     = bit_buffer_q;
		nxt_bit_count  = bit_count_q;
		nxt_byte_count = byte_count_q;

		if (!decode_mode_q) begin
			if (item_s1.operation == OP_DATA) begin
				nxt_chars[0]   = s1;
				nxt_chars[1]   = nl ? NEWLINE : s2;
				nxt_chars[2]   = s2;
				nxt_cnt        = 2'd1 + {1'b0, two} + {1'b0, nl};
				nxt_buffer     = 12'(acc_e & ~(20'hFFFFF << rem_e));
				nxt_bit_count  = 4'(rem_e);
				nxt_byte_count = nl ? 8'd0 : bcnt_inc;
			end else begin
				nxt_chars[0]   = have ? fsym : NEWLINE;
				nxt_cnt        = (have ? 2'd2 : 2'd0) + {1'b0, extra};
				nxt_buffer     = '0;
				nxt_bit_count  = '0;
				nxt_byte_count = '0;
			end
		end else begin
			if (item_s1.operation == OP_DATA) begin
				nxt_chars[0] = 8'(acc_d >> rem_d);
				if (ok) begin
					nxt_cnt       = {1'b0, ge};
					nxt_buffer    = 12'(acc_d & ~(17'h1FFFF << rem_d));
					nxt_bit_count = 4'(rem_d);
				end
			end else begin
				nxt_buffer     = '0;
				nxt_bit_count  = '0;
				nxt_byte_count = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q <= 1'b0;
			line_limit_q  <= LINE_LIMIT_RESET;
			bit_buffer_q  <= '0;
			bit_count_q   <= '0;
			byte_count_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DECODE_MODE: begin
					decode_mode_q <= cfg_wdata[0];
					bit_buffer_q  <= '0;
					bit_count_q   <= '0;
					byte_count_q  <= '0;
				end
				CFG_LINE_LIMIT: begin
					line_limit_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end else if (adv) begin
			bit_buffer_q <= nxt_buffer;
			bit_count_q  <= nxt_bit_count;
			byte_count_q <= nxt_byte_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			res_left_q <= 2'd0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (adv) begin
				res_left_q <= nxt_cnt;
			end else if (result_valid && result_ready) begin
				res_left_q <= res_left_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
		if (adv) begin
			chars_q <= nxt_chars;
		end else if (result_valid && result_ready) begin
			// shift the next word to the head
			chars_q[0] <= chars_q[1];
			chars_q[1] <= chars_q[2];
		end
	end

	a_enc_bits: assert property (@(posedge clk) disable iff (!arst_n)
		!decode_mode_q |-> bit_count_q < 4'd5)
		else $error("encoder holds five or more pending bits");

	a_dec_bits: assert property (@(posedge clk) disable iff (!arst_n)
		decode_mode_q |-> bit_count_q < 4'd8)
		else $error("decoder holds eight or more pending bits");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> res_left_q == $past(nxt_cnt))
		else $error("result register not loaded with the item's word count");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> valid_s1 && res_left_q != 2'd0)
		else $error("item side stalled with nothing pending");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// tb: self-checking testbench for five_bit_text_codec (encode and decode, flush, line breaks)
// depends on fbtc_pkg and rtl/five_bit_text_codec.sv; predicts every output word in-line
`timescale 1ns / 1ps

module tb;
	import fbtc_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	in_item_t    item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	out_item_t   result;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_wdata = '0;

	// predicted codec state and registers
	logic        dec_mode;
	logic [7:0]  line_lim;
	logic [11:0] bit_buf;
	logic [3:0]  bit_cnt;
	logic [7:0]  bytes_seen;

	in_item_t    pending_words[$];
	out_item_t   expected_chars[$];
	int          bad_words = 0;
	int          send_gap = 0;
	int          hold_left = 0;
	logic        calm = 1'b0;
	logic        hold_request = 1'b0;

	five_bit_text_codec u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("tb NOT OK");
		$finish;
	end

	function automatic logic [7:0] to_symbol(input logic [4:0] v);
		if (v < SYM_ALPHA_CNT) begin
			return SYM_ALPHA_BASE + 8'(v);
		end else begin
			return SYM_DIGIT_BASE + 8'(v) - 8'(SYM_ALPHA_CNT);
		end
	endfunction

	function automatic void clear_stream();
		bit_buf = '0;
		bit_cnt = '0;
		bytes_seen = '0;
	endfunction

	// works out the output characters of one accepted word and queues them
	function automatic void codec_predict(input in_item_t w);
		logic [7:0]  outs[3];
		logic [31:0] acc;
		logic [31:0] v;
		int          cnt;
		int          n;
		out_item_t   r;
		n = 0;
		if (!dec_mode) begin
			if (w.operation == OP_DATA) begin
				if (bytes_seen != 8'hFF) begin
					bytes_seen++;
				end
				acc = ({20'b0, bit_buf} << 8) | {24'b0, w.data};
				cnt = int'(bit_cnt) + 8;
				while (cnt >= 5 && n < 3) begin
					cnt -= 5;
					outs[n] = to_symbol(5'(acc >> cnt));
					n++;
					if (bytes_seen > line_lim) begin
						if (n < 3) begin
							outs[n] = NEWLINE;
							n++;
						end
						bytes_seen = '0;
					end
				end
				if (cnt > 12) begin
					cnt = 12;
				end
				bit_buf = 12'(acc & ((32'd1 << cnt) - 1));
				bit_cnt = 4'(cnt);
			end else begin
				cnt = int'(bit_cnt);
				if (cnt > 0) begin
					// pad pending bits with zeros on the right
					if (cnt < 5) begin
						v = {20'b0, bit_buf} << (5 - cnt);
					end else begin
						v = {20'b0, bit_buf} >> (cnt - 5);
					end
					outs[n] = to_symbol(v[4:0]);
					n++;
					outs[n] = NEWLINE;
					n++;
				end
				if (bytes_seen > FLUSH_EXTRA_MAX) begin
					outs[n] = NEWLINE;
					n++;
				end
				clear_stream();
			end
		end else begin
			if (w.operation == OP_DATA) begin
				cnt = -1;
				if (w.data >= SYM_ALPHA_BASE && w.data <= SYM_ALPHA_END) begin
					v = {24'b0, w.data - SYM_ALPHA_BASE};
					cnt = int'(bit_cnt) + 5;
				end else if (w.data >= SYM_DIGIT_BASE && w.data <= SYM_DIGIT_END) begin
					v = {24'b0, w.data - SYM_DIGIT_BASE} + 32'(SYM_ALPHA_CNT);
					cnt = int'(bit_cnt) + 5;
				end
				// other characters leave the state alone
				if (cnt >= 0) begin
					acc = ({20'b0, bit_buf} << 5) | v;
					if (cnt >= 8) begin
						cnt -= 8;
						outs[n] = 8'(acc >> cnt);
						n++;
					end
					if (cnt > 12) begin
						cnt = 12;
					end
					bit_buf = 12'(acc & ((32'd1 << cnt) - 1));
					bit_cnt = 4'(cnt);
				end
			end else begin
				clear_stream();
			end
		end
		for (int i = 0; i < n; i++) begin
			r.out_char = outs[i];
			r.last = (i == n - 1);
			expected_chars.push_back(r);
		end
	endfunction

	// mostly no gap, some short ones, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm) begin
			return 0;
		end else if (r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end else begin
			return $urandom_range(20, 60);
		end
	endfunction

	function automatic logic [7:0] rand_symbol();
		logic [4:0] v;
		v = 5'($urandom_range(0, 31));
		return to_symbol(v);
	endfunction

	function automatic void send(input logic op, input logic [7:0] d);
		in_item_t w;
		w.operation = op;
		w.data = d;
		pending_words.push_back(w);
	endfunction

	task automatic set_reg(input logic [1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == CFG_DECODE_MODE) begin
			dec_mode = val[0];
			clear_stream();
		end else if (idx == CFG_LINE_LIMIT) begin
			line_lim = val;
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// all words sent, all characters seen, then room for words that make no output
	task automatic drain();
		while (pending_words.size() != 0 || item_valid || expected_chars.size() != 0) begin
			@(negedge clk);
		end
		repeat (12) @(negedge clk);
	endtask

	// word driver
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				codec_predict(item);
			end
			if (!item_valid || item_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					item_valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					item <= pending_words.pop_front();
					item_valid <= 1'b1;
					send_gap = pick_gap();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// character monitor and receiver stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_chars.size() == 0) begin
					bad_words++;
					if (bad_words <= 10) begin
						$display("unexpected word: char %02h last %0d", result.out_char,
							result.last);
					end
				end else begin
					if (result != expected_chars[0]) begin
						bad_words++;
						if (bad_words <= 10) begin
							$display("mismatch: expected char %02h last %0d, got char %02h last %0d",
								expected_chars[0].out_char, expected_chars[0].last,
								result.out_char, result.last);
						end
					end
					void'(expected_chars.pop_front());
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (hold_request) begin
				// long hold-off so the codec backs up into its input
				hold_request = 1'b0;
				hold_left = 400;
				result_ready <= 1'b0;
			end else begin
				hold_left = pick_gap();
				result_ready <= (hold_left == 0);
			end
		end
	end

	initial begin
		logic [7:0] lim;
		int         r;
		dec_mode = 1'b0;
		line_lim = LINE_LIMIT_RESET;
		clear_stream();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// encode at reset settings: extremes, flush with bits, flush with nothing
		send(OP_DATA, 8'h00);
		send(OP_DATA, 8'hFF);
		send(OP_DATA, 8'h80);
		send(OP_DATA, 8'h01);
		send(OP_FLUSH, 8'hFF);
		send(OP_FLUSH, 8'h00);
		drain();

		// line limit zero: newline after every first symbol
		set_reg(CFG_LINE_LIMIT, 8'd0);
		send(OP_DATA, 8'hFF);
		send(OP_DATA, 8'h00);
		send(OP_DATA, 8'h7C);
		send(OP_FLUSH, 8'h55);
		drain();

		// decode: alphabet ends, characters just outside it, flush dropping bits
		set_reg(CFG_DECODE_MODE, 8'd1);
		send(OP_DATA, "A");
		send(OP_DATA, "Z");
		send(OP_DATA, "0");
		send(OP_DATA, "5");
		send(OP_DATA, "6");
		send(OP_DATA, 8'h40);
		send(OP_DATA, 8'h5B);
		send(OP_DATA, 8'h2F);
		send(OP_DATA, 8'h00);
		send(OP_DATA, 8'hFF);
		send(OP_DATA, "M");
		send(OP_DATA, "Q");
		send(OP_DATA, "B");
		send(OP_FLUSH, 8'hAA);
		send(OP_DATA, "C");
		drain();
		// mode change drops the pending decode bits
		set_reg(CFG_DECODE_MODE, 8'd0);

		for (int ph = 0; ph < 4; ph++) begin
			calm = ($urandom_range(0, 3) == 0);
			set_reg(CFG_DECODE_MODE, 8'($urandom_range(0, 1)));
			r = $urandom_range(0, 4);
			case (r)
				0: lim = 8'd1;
				1: lim = 8'd0;
				2: lim = 8'd255;
				default: lim = 8'($urandom_range(2, 80));
			endcase
			set_reg(CFG_LINE_LIMIT, lim);
			if (ph == 2) begin
				calm = 1'b1;
				hold_request = 1'b1;
			end
			for (int k = 0; k < 8; k++) begin
				r = $urandom_range(0, 99);
				if (dec_mode) begin
					if (r < 80) begin
						send(OP_DATA, rand_symbol());
					end else if (r < 95) begin
						send(OP_DATA, 8'($urandom_range(0, 255)));
					end else begin
						send(OP_FLUSH, 8'($urandom_range(0, 255)));
					end
				end else begin
					if (r < 92) begin
						send(OP_DATA, 8'($urandom_range(0, 255)));
					end else begin
						send(OP_FLUSH, 8'($urandom_range(0, 255)));
					end
				end
			end
			drain();
		end

		// long encode stream at line limit 255: byte count saturates, flush adds a newline
		calm = 1'b0;
		set_reg(CFG_DECODE_MODE, 8'd0);
		set_reg(CFG_LINE_LIMIT, 8'd255);
		for (int k = 0; k < 256; k++) begin
			send(OP_DATA, 8'($urandom_range(0, 255)));
		end
		send(OP_FLUSH, 8'($urandom_range(0, 255)));
		drain();

		// back to a small limit in decode to end on another setting
		set_reg(CFG_LINE_LIMIT, 8'd1);
		set_reg(CFG_DECODE_MODE, 8'd1);
		for (int k = 0; k < 8; k++) begin
			send(OP_DATA, rand_symbol());
		end
		send(OP_FLUSH, 8'h00);
		drain();

		repeat (20) @(negedge clk);
		if (bad_words == 0 && expected_chars.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

// ===== five_bit_text_codec.f =====
rtl/fbtc_pkg.sv
rtl/five_bit_text_codec.sv
tb/tb.sv
